FILE: hw/rtl/lzwc_pkg.sv
// Shared constants and types for the LZW 9-bit code compressor.
`timescale 1ns / 1ps

package lzwc_pkg;

    // Defaults for the top-level parameters
    localparam int DICT_ENTRIES_DEF = 512;
    localparam int CODE_BITS_DEF    = 9;

    // Fixed code assignments
    localparam int BYTE_W     = 8;
    localparam int ROOT_CODES = 256;
    localparam int ROOT_W     = 8;
    localparam int END_CODE   = 256;
    localparam int FIRST_FREE = 257;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FC_CHK,
        S_ND_CHK,
        S_MISS,
        S_INS1,
        S_INS2,
        S_FIN1,
        S_FIN2
    } t_state;

    // Control from the sequencer to the bit packer
    typedef struct packed {
        logic valid;
        logic flush;
    } t_pack_ctl;

endpackage

FILE: hw/rtl/lzwc_if.sv
// Valid/ready stream interfaces for message bytes in and packed bytes out.
`timescale 1ns / 1ps

interface lzwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzwc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_out;

    modport source (output valid, output out_byte, output last_out, input ready);
    modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

FILE: hw/rtl/lzwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lzwc_packer.sv
// Bit packer: appends codes LSB-first and drains whole bytes to the output register.
`timescale 1ns / 1ps

module lzwc_packer #(
    parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzwc_pkg::t_pack_ctl  i_ctl,
    input  logic [CODE_BITS-1:0] i_code,
    output logic                 o_code_ready,
    lzwc_out_if.source           o_out
);

    localparam int ACC_W = CODE_BITS + lzwc_pkg::BYTE_W - 1;
    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam logic [CNT_W-1:0] BYTE_CNT = CNT_W'(lzwc_pkg::BYTE_W);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_flush, n_flush;
    logic             r_ov, n_ov;
    logic [7:0]       r_ob, n_ob;
    logic             r_ol, n_ol;

    logic w_full;
    logic w_slot_free;
    logic w_push;
    logic w_take;

    assign w_full       = (r_cnt >= BYTE_CNT);
    assign w_slot_free  = !r_ov || o_out.ready;
    assign w_push       = w_slot_free && (w_full || (r_flush && (r_cnt != '0)));
    assign o_code_ready = !w_full && !r_flush;
    assign w_take       = i_ctl.valid && o_code_ready;

    // Append a code, or drain one byte when a request slot is free
    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_flush = r_flush;
        n_ov    = r_ov;
        n_ob    = r_ob;
        n_ol    = r_ol;
        if (w_slot_free) begin
            n_ov = 1'b0;
        end
        if (w_take) begin
            n_acc   = r_acc | (ACC_W'(i_code) << r_cnt);
            n_cnt   = r_cnt + CNT_W'(CODE_BITS);
            n_flush = i_ctl.flush;
        end else if (w_push) begin
            n_ov = 1'b1;
            n_ob = r_acc[7:0];
            if (w_full) begin
                n_acc = r_acc >> lzwc_pkg::BYTE_W;
                n_cnt = r_cnt - BYTE_CNT;
                n_ol  = r_flush && (r_cnt == BYTE_CNT);
                if (r_cnt == BYTE_CNT) begin
                    n_flush = 1'b0;
                end
            end else begin
                // Partial byte at end of message: high bits are already zero
                n_acc   = '0;
                n_cnt   = '0;
                n_ol    = 1'b1;
                n_flush = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_flush <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
            r_ov    <= n_ov;
        end
    end

    // Output payload holds without reset
    always_ff @(posedge i_clk) begin
        r_ob <= n_ob;
        r_ol <= n_ol;
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last_out = r_ol;

endmodule

FILE: hw/rtl/lzw_compressor_9bit_top.sv
// Top level of the LZW compressor: dictionary sequencer, dictionary RAMs and bit packer.
`timescale 1ns / 1ps

// LZW compressor with fixed-width codes, one message byte per request on i_in and packed
// code bytes (LSB-first, last_out on the final byte) on o_out. The dictionary is a
// child/sibling tree in two RAMs with registered reads; every lookup walks it one node a
// cycle. The first byte of a message only sets the prefix. A later byte reads the prefix's
// child link, walks the sibling chain until it hits or runs out, and on a miss emits the
// code, then writes the new node and links it, unless the dictionary is full. A last
// byte adds two code emits. The bit packer drains one byte a cycle while the receiver
// keeps up. Input ready is held low while an item is in work; the output register lets a
// finished byte wait without stalling the sequencer. The dictionary restarts at once after
// each message: root links are guarded by one valid flag per byte value, so no clearing
// pass is needed.
module lzw_compressor_9bit_top #(
    parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF,
    parameter int CODE_BITS    = lzwc_pkg::CODE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzwc_in_if.sink    i_in,
    lzwc_out_if.source o_out
);

    localparam int IDX_W  = $clog2(DICT_ENTRIES);
    localparam int NFC_W  = IDX_W + 1;
    localparam int NODE_W = IDX_W + lzwc_pkg::BYTE_W;

    lzwc_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]                r_prefix, n_prefix;
    logic                            r_have, n_have;
    logic [NFC_W-1:0]                r_nfc, n_nfc;
    logic [lzwc_pkg::ROOT_CODES-1:0] r_valid, n_valid;
    logic [7:0]                      r_d, n_d;
    logic                            r_last, n_last;
    logic [IDX_W-1:0]                r_rv, n_rv;
    logic [IDX_W-1:0]                r_head, n_head;

    // RAM ports
    logic              w_fc_we;
    logic [IDX_W-1:0]  w_fc_waddr, w_fc_wdata, w_fc_raddr, w_fc_rdata;
    logic              w_nd_we;
    logic [IDX_W-1:0]  w_nd_waddr, w_nd_raddr;
    logic [NODE_W-1:0] w_nd_wdata, w_nd_rdata;

    // Packer link
    lzwc_pkg::t_pack_ctl  w_pack_ctl;
    logic [CODE_BITS-1:0] w_pack_code;
    logic                 w_pack_ready;

    logic             w_accept;
    logic             w_root;
    logic             w_root_ok;
    logic [IDX_W-1:0] w_head;
    logic [7:0]       w_nd_char;
    logic [IDX_W-1:0] w_nd_sib;
    logic             w_match;
    logic             w_room;

    assign i_in.ready = (r_state == lzwc_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // Root codes keep their child link valid only within the current message
    assign w_root    = (r_prefix >> lzwc_pkg::ROOT_W) == '0;
    assign w_root_ok = !w_root || r_valid[r_prefix[lzwc_pkg::ROOT_W-1:0]];
    assign w_head    = w_fc_rdata & {IDX_W{w_root_ok}};
    assign w_nd_char = w_nd_rdata[lzwc_pkg::BYTE_W-1:0];
    assign w_nd_sib  = w_nd_rdata[NODE_W-1:lzwc_pkg::BYTE_W];
    assign w_match   = (w_nd_char == r_d);
    assign w_room    = (r_nfc < NFC_W'(DICT_ENTRIES));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzwc_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!r_have) begin
                        n_state = i_in.last_byte ? lzwc_pkg::S_FIN1 : lzwc_pkg::S_IDLE;
                    end else begin
                        n_state = lzwc_pkg::S_FC_CHK;
                    end
                end
            end
            lzwc_pkg::S_FC_CHK: begin
                n_state = (w_head == '0) ? lzwc_pkg::S_MISS : lzwc_pkg::S_ND_CHK;
            end
            lzwc_pkg::S_ND_CHK: begin
                if (w_match) begin
                    n_state = r_last ? lzwc_pkg::S_FIN1 : lzwc_pkg::S_IDLE;
                end else if (w_nd_sib == '0) begin
                    n_state = lzwc_pkg::S_MISS;
                end
            end
            lzwc_pkg::S_MISS: begin
                if (w_pack_ready) begin
                    if (w_room) begin
                        n_state = lzwc_pkg::S_INS1;
                    end else begin
                        n_state = r_last ? lzwc_pkg::S_FIN1 : lzwc_pkg::S_IDLE;
                    end
                end
            end
            lzwc_pkg::S_INS1: begin
                n_state = lzwc_pkg::S_INS2;
            end
            lzwc_pkg::S_INS2: begin
                n_state = r_last ? lzwc_pkg::S_FIN1 : lzwc_pkg::S_IDLE;
            end
            lzwc_pkg::S_FIN1: begin
                if (w_pack_ready) begin
                    n_state = lzwc_pkg::S_FIN2;
                end
            end
            lzwc_pkg::S_FIN2: begin
                if (w_pack_ready) begin
                    n_state = lzwc_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Datapath controls and register updates
    always_comb begin
        n_prefix    = r_prefix;
        n_have      = r_have;
        n_nfc       = r_nfc;
        n_valid     = r_valid;
        n_d         = r_d;
        n_last      = r_last;
        n_rv        = r_rv;
        n_head      = r_head;
        w_fc_we     = 1'b0;
        w_fc_waddr  = r_nfc[IDX_W-1:0];
        w_fc_wdata  = '0;
        w_fc_raddr  = r_prefix;
        w_nd_we     = 1'b0;
        w_nd_waddr  = r_nfc[IDX_W-1:0];
        w_nd_wdata  = {r_head, r_d};
        w_nd_raddr  = r_rv;
        w_pack_ctl  = '0;
        w_pack_code = CODE_BITS'(r_prefix);
        unique case (r_state)
            lzwc_pkg::S_IDLE: begin
                // Take the byte; the child link of the prefix is read meanwhile
                if (w_accept) begin
                    n_d    = i_in.data_byte;
                    n_last = i_in.last_byte;
                    if (!r_have) begin
                        n_prefix = IDX_W'(i_in.data_byte);
                        n_have   = 1'b1;
                    end
                end
            end
            lzwc_pkg::S_FC_CHK: begin
                n_head     = w_head;
                n_rv       = w_head;
                w_nd_raddr = w_head;
            end
            lzwc_pkg::S_ND_CHK: begin
                // Extend on a match, else advance along the sibling chain
                if (w_match) begin
                    n_prefix = r_rv;
                end else begin
                    n_rv       = w_nd_sib;
                    w_nd_raddr = w_nd_sib;
                end
            end
            lzwc_pkg::S_MISS: begin
                w_pack_ctl.valid = 1'b1;
                if (w_pack_ready && !w_room) begin
                    n_prefix = IDX_W'(r_d);
                end
            end
            lzwc_pkg::S_INS1: begin
                // New node: char, old head as sibling, no child yet
                w_nd_we = 1'b1;
                w_fc_we = 1'b1;
            end
            lzwc_pkg::S_INS2: begin
                // Link the new node as head child of the prefix
                w_fc_we    = 1'b1;
                w_fc_waddr = r_prefix;
                w_fc_wdata = r_nfc[IDX_W-1:0];
                if (w_root) begin
                    n_valid[r_prefix[lzwc_pkg::ROOT_W-1:0]] = 1'b1;
                end
                n_nfc    = r_nfc + NFC_W'(1);
                n_prefix = IDX_W'(r_d);
            end
            lzwc_pkg::S_FIN1: begin
                w_pack_ctl.valid = 1'b1;
            end
            lzwc_pkg::S_FIN2: begin
                // Emit end code, flush and restart the dictionary
                w_pack_ctl.valid = 1'b1;
                w_pack_ctl.flush = 1'b1;
                w_pack_code      = CODE_BITS'(lzwc_pkg::END_CODE);
                if (w_pack_ready) begin
                    n_have   = 1'b0;
                    n_nfc    = NFC_W'(lzwc_pkg::FIRST_FREE);
                    n_valid  = '0;
                    n_prefix = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzwc_pkg::S_IDLE;
            r_prefix <= '0;
            r_have   <= 1'b0;
            r_nfc    <= NFC_W'(lzwc_pkg::FIRST_FREE);
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_have   <= n_have;
            r_nfc    <= n_nfc;
            r_valid  <= n_valid;
        end
    end

    // Item payload and walk pointers hold without reset
    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_last <= n_last;
        r_rv   <= n_rv;
        r_head <= n_head;
    end

    // First-child links
    lzwc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DICT_ENTRIES)
    ) u_fc_ram (
        .i_clk   (i_clk),
        .i_we    (w_fc_we),
        .i_waddr (w_fc_waddr),
        .i_wdata (w_fc_wdata),
        .i_raddr (w_fc_raddr),
        .o_rdata (w_fc_rdata)
    );

    // Node store: next sibling and entry char
    lzwc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DICT_ENTRIES)
    ) u_nd_ram (
        .i_clk   (i_clk),
        .i_we    (w_nd_we),
        .i_waddr (w_nd_waddr),
        .i_wdata (w_nd_wdata),
        .i_raddr (w_nd_raddr),
        .o_rdata (w_nd_rdata)
    );

    lzwc_packer #(
        .CODE_BITS (CODE_BITS)
    ) u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_pack_ctl),
        .i_code       (w_pack_code),
        .o_code_ready (w_pack_ready),
        .o_out        (o_out)
    );

endmodule

FILE: dv/lzw_compressor_9bit_top_test.sv
// Self-checking test of the LZW 9-bit compressor: message streams in, packed code bytes checked.
`timescale 1ns / 1ps

// Track the compressed byte stream that the block owes for each accepted request
class lzw_stream_scoreboard;
    typedef struct packed {
        bit [7:0] data;
        bit       last;
    } packed_byte_t;

    packed_byte_t expected_bytes[$];
    int unsigned  errors;

    // Model state: dictionary keyed by {prefix code, byte}
    bit [8:0]  code_of[bit [16:0]];
    bit [8:0]  cur_prefix;
    bit [9:0]  next_code;
    bit        have_prefix;
    bit [15:0] pend_bits;
    int        pend_cnt;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        code_of.delete();
        next_code   = 10'(lzwc_pkg::FIRST_FREE);
        cur_prefix  = '0;
        have_prefix = 1'b0;
        pend_bits   = '0;
        pend_cnt    = 0;
    endfunction

    // Append one code LSB-first and release every whole byte
    function void pack_code(bit [8:0] code);
        packed_byte_t pb;
        pend_bits = pend_bits | (16'(code) << pend_cnt);
        pend_cnt  = pend_cnt + lzwc_pkg::CODE_BITS_DEF;
        while (pend_cnt >= 8) begin
            pb.data = pend_bits[7:0];
            pb.last = 1'b0;
            expected_bytes.push_back(pb);
            pend_bits = pend_bits >> 8;
            pend_cnt  = pend_cnt - 8;
        end
    endfunction

    // Advance the compressor by one accepted message byte
    function void compress_byte(bit [7:0] d, bit l);
        bit [16:0]    key;
        packed_byte_t pb;
        key = {cur_prefix, d};
        if (!have_prefix) begin
            cur_prefix  = 9'(d);
            have_prefix = 1'b1;
        end else if (code_of.exists(key)) begin
            cur_prefix = code_of[key];
        end else begin
            pack_code(cur_prefix);
            // Add the pair only while free codes remain
            if (next_code < 10'(lzwc_pkg::DICT_ENTRIES_DEF)) begin
                code_of[key] = next_code[8:0];
                next_code    = next_code + 10'd1;
            end
            cur_prefix = 9'(d);
        end
        if (l) begin
            pack_code(cur_prefix);
            pack_code(9'(lzwc_pkg::END_CODE));
            if (pend_cnt > 0) begin
                pb.data = pend_bits[7:0];
                pb.last = 1'b0;
                expected_bytes.push_back(pb);
            end
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            restart();
        end
    endfunction

    // Compare one output byte against the oldest expectation
    function void check_packed_byte(bit [7:0] d, bit l);
        packed_byte_t pb;
        if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected output byte: expected none, actual data %02h last %0b",
                     $time, d, l);
            errors++;
            return;
        end
        pb = expected_bytes.pop_front();
        if (pb.data !== d) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, pb.data, d);
            errors++;
        end
        if (pb.last !== l) begin
            $display("%0t: last_out mismatch: expected %0b, actual %0b", $time, pb.last, l);
            errors++;
        end
    endfunction

    function int unsigned outstanding();
        return expected_bytes.size();
    endfunction
endclass

module lzw_compressor_9bit_top_test;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 200;
    localparam int LONG_MSG_LEN  = 270;
    localparam int SETTLE_CYCLES = 20;

    // Byte choice for random messages
    localparam int PICK_ANY    = 0;
    localparam int PICK_NEAR   = 1;
    localparam int PICK_BINARY = 2;
    localparam int PICK_RUN    = 3;

    logic i_clk;
    logic i_rst_n;

    lzwc_in_if  in_bus();
    lzwc_out_if out_bus();

    lzw_compressor_9bit_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    lzw_stream_scoreboard sb = new();

    int burst_left;
    int steady;
    int random_sent;
    int rx_mode  = 0;
    int rx_phase = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: stall on a pattern whose mode is picked at random
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase % 50 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                out_bus.ready <= 1'b1;
            end
            1: begin
                out_bus.ready <= $urandom_range(0, 1);
            end
            2: begin
                out_bus.ready <= (rx_phase % 4 == 0);
            end
            default: begin
                out_bus.ready <= (rx_phase % 7 != 3);
            end
        endcase
    end

    // Check every accepted output byte
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_packed_byte(out_bus.out_byte, out_bus.last_out);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Send one message byte, with bursty gaps, and hold until accepted
    task automatic send_byte(input bit [7:0] d, input bit l);
        int gap;
        if (burst_left == 0) begin
            gap = (steady != 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= d;
        in_bus.last_byte <= l;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        sb.compress_byte(d, l);
    endtask

    task automatic send_message(input int len, input int pick);
        bit [7:0] base;
        bit [7:0] d;
        base = $urandom_range(0, 255);
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            case (pick)
                PICK_NEAR: begin
                    d = base + 8'($urandom_range(0, 2));
                end
                PICK_BINARY: begin
                    d = $urandom_range(0, 1) ? base : ~base;
                end
                PICK_RUN: begin
                    d = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : base;
                end
                default: begin
                    d = $urandom_range(0, 255);
                end
            endcase
            send_byte(d, i == len - 1);
        end
    endtask

    task automatic send_fixed(input bit [7:0] msg[$]);
        for (int i = 0; i < msg.size(); i++) begin
            send_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    initial begin
        bit long_done;
        int len;
        // Drive known values from the start
        i_rst_n          <= 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.data_byte <= '0;
        in_bus.last_byte <= 1'b0;
        burst_left  = 0;
        steady      = 0;
        random_sent = 0;
        long_done   = 1'b0;

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-byte messages at both extremes
        send_fixed('{8'h00});
        send_fixed('{8'hFF});
        // Repeated byte: hits that grow the prefix
        send_fixed('{8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41});
        // Alternating extremes: mixed hits and misses
        send_fixed('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
        // Distinct bytes: every byte after the first misses, last one included, so output bunches up
        send_fixed('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80});

        // Random messages, with one among them long enough to fill the dictionary
        while (random_sent < RANDOM_ITEMS) begin
            if (!long_done && random_sent >= RANDOM_ITEMS / 8) begin
                send_message(LONG_MSG_LEN, PICK_ANY);
                random_sent += LONG_MSG_LEN;
                long_done = 1'b1;
            end else begin
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
                send_message(len, $urandom_range(PICK_ANY, PICK_RUN));
                random_sent += len;
            end
        end

        in_bus.valid <= 1'b0;

        // Drain, then let the settle time pass to catch stray bytes
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
